>>> rtl/pcl_pkg.sv
// Shared definitions for the partitioned convolution layer.
// Holds default sizes, action codes, width helpers and controller/datapath structs.
// No dependencies.
package pcl_pkg;

    // Default layer geometry
    localparam int DEF_OUT_CHANNELS  = 20;
    localparam int DEF_IN_CHANNELS   = 1;
    localparam int DEF_KERNEL        = 5;
    localparam int DEF_IN_SIZE       = 28;
    localparam int DEF_ROWS_PER_PART = 12;
    localparam int DEF_PARTS         = 2;

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int DATA_W   = 32;
    localparam int COORD_W  = 5;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BIAS   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIXEL  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EMIT   = 2'd3;

    // Bits needed to index n entries (at least one)
    function automatic int cw(input int n);
        cw = (n > 1) ? $clog2(n) : 1;
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic idle;      // controller can take an input transfer
        logic setup;     // latch coordinates, bases, advance cursor
        logic issue;     // read one weight/pixel pair
        logic load_out;  // move final sum into the output register
    } pcl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic part_empty;  // current partition has no outputs
        logic issue_last;  // current read is the last term
        logic pipe_busy;   // products still in flight
        logic out_busy;    // output register held this cycle
    } pcl_status_t;

endpackage

>>> rtl/pcl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on pcl_pkg for the width helper.
module pcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [pcl_pkg::cw(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [pcl_pkg::cw(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pcl_ctrl.sv
// Controller state machine for the convolution layer.
// Depends on pcl_pkg for command/status structs and action codes.
module pcl_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [pcl_pkg::ACTION_W-1:0]      action,
    input  pcl_pkg::pcl_status_t              status,
    output pcl_pkg::pcl_cmd_t                 cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       emit_go;

    // Start a computation on an emit transfer for a non-empty partition
    assign emit_go = (state_reg == ST_IDLE) && in_valid && (action == pcl_pkg::ACT_EMIT)
                     && !status.part_empty;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (emit_go)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && !status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd.idle     = (state_reg == ST_IDLE);
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.issue    = (state_reg == ST_RUN);
        cmd.load_out = (state_reg == ST_DRAIN) && !status.pipe_busy && !status.out_busy;
    end

endmodule

>>> rtl/pcl_dp.sv
// Datapath for the convolution layer: stores, cursor, address generation,
// multiply-accumulate pipeline and output register.
// Depends on pcl_pkg and pcl_ram.
module pcl_dp #(
    parameter int OUT_CHANNELS  = pcl_pkg::DEF_OUT_CHANNELS,
    parameter int IN_CHANNELS   = pcl_pkg::DEF_IN_CHANNELS,
    parameter int KERNEL        = pcl_pkg::DEF_KERNEL,
    parameter int IN_SIZE       = pcl_pkg::DEF_IN_SIZE,
    parameter int ROWS_PER_PART = pcl_pkg::DEF_ROWS_PER_PART,
    parameter int PARTS         = pcl_pkg::DEF_PARTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic                               cfg_write_data,
    input  logic                               in_valid,
    input  logic [pcl_pkg::ACTION_W-1:0]       action,
    input  logic [pcl_pkg::INDEX_W-1:0]        index,
    input  logic signed [pcl_pkg::DATA_W-1:0]  value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [pcl_pkg::DATA_W-1:0]  out_value,
    output logic [pcl_pkg::COORD_W-1:0]        out_row,
    output logic [pcl_pkg::COORD_W-1:0]        out_col,
    output logic [pcl_pkg::COORD_W-1:0]        out_channel,
    output logic                               last,
    output logic                               saturated,
    input  pcl_pkg::pcl_cmd_t                  cmd,
    output pcl_pkg::pcl_status_t               status
);

    // Geometry
    localparam int OUT_SIZE = (IN_SIZE >= KERNEL) ? IN_SIZE - KERNEL + 1 : 0;
    localparam int TERMS    = IN_CHANNELS * KERNEL * KERNEL;
    localparam int W_DEPTH  = OUT_CHANNELS * TERMS;
    localparam int B_DEPTH  = OUT_CHANNELS;
    localparam int P_DEPTH  = IN_CHANNELS * IN_SIZE * IN_SIZE;
    localparam int W_AW     = pcl_pkg::cw(W_DEPTH);
    localparam int B_AW     = pcl_pkg::cw(B_DEPTH);
    localparam int P_AW     = pcl_pkg::cw(P_DEPTH);
    localparam int RO_W     = pcl_pkg::cw(ROWS_PER_PART);
    localparam int COL_W    = pcl_pkg::cw(OUT_SIZE);
    localparam int ROW_W    = pcl_pkg::cw(OUT_SIZE);
    localparam int CH_W     = pcl_pkg::cw(OUT_CHANNELS);
    localparam int KC_W     = pcl_pkg::cw(KERNEL);
    localparam int M_W      = pcl_pkg::cw(IN_CHANNELS);
    localparam int DW       = pcl_pkg::DATA_W;
    localparam int ACC_W    = pcl_pkg::ACC_W;

    // Partition bounds for the two selectable partitions
    localparam int END0   = (ROWS_PER_PART < OUT_SIZE) ? ROWS_PER_PART : OUT_SIZE;
    localparam int END1   = (2 * ROWS_PER_PART < OUT_SIZE) ? 2 * ROWS_PER_PART : OUT_SIZE;
    localparam bit EMPTY0 = (END0 <= 0);
    localparam bit EMPTY1 = (PARTS < 2) || (ROWS_PER_PART >= END1);

    // Pixel address steps: next column, next kernel row, next input channel
    localparam int PSTEP_ROW = IN_SIZE - KERNEL + 1;
    localparam int PSTEP_CH  = IN_SIZE * IN_SIZE - (KERNEL - 1) * IN_SIZE - (KERNEL - 1);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

    // Configuration and cursor
    logic                 part_index_reg;
    logic [RO_W-1:0]      off_reg;
    logic [RO_W-1:0]      off_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [CH_W-1:0]      ch_reg;
    logic [CH_W-1:0]      ch_next;

    // Current output coordinates
    logic [ROW_W-1:0]     row_pos_reg;
    logic [COL_W-1:0]     col_pos_reg;
    logic [CH_W-1:0]      ch_pos_reg;
    logic                 last_pos_reg;

    // Effective cursor after restart check
    int                   part_start;
    int                   part_end;
    logic                 restart;
    logic [RO_W-1:0]      off_eff;
    logic [COL_W-1:0]     col_eff;
    logic [CH_W-1:0]      ch_eff;
    logic [ROW_W-1:0]     row_eff;
    logic                 last_eff;
    logic [W_AW-1:0]      wbase;
    logic [P_AW-1:0]      pbase;

    // Address generation
    logic [W_AW-1:0]      wa_reg;
    logic [P_AW-1:0]      pa_reg;
    logic [KC_W-1:0]      kc_reg;
    logic [KC_W-1:0]      kr_reg;
    logic [M_W-1:0]       m_reg;
    logic                 kc_end;
    logic                 kr_end;
    logic                 m_end;

    // Memory ports
    logic                 w_we;
    logic                 b_we;
    logic                 p_we;
    logic [DW-1:0]        w_rdata;
    logic [DW-1:0]        b_rdata;
    logic [DW-1:0]        p_rdata;
    logic                 in_xfer;

    // MAC pipeline
    logic                        rd_v_reg;
    logic                        bias_v_reg;
    logic                        mul_v_reg;
    logic signed [pcl_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    // Output register
    logic                        out_valid_reg;
    logic signed [DW-1:0]        out_value_reg;
    logic [pcl_pkg::COORD_W-1:0] out_row_reg;
    logic [pcl_pkg::COORD_W-1:0] out_col_reg;
    logic [pcl_pkg::COORD_W-1:0] out_ch_reg;
    logic                        out_last_reg;
    logic                        out_sat_reg;
    logic signed [DW-1:0]        sat_value;
    logic                        sat_flag;

    // Write enables for store transfers, out-of-range addresses dropped
    assign in_xfer = in_valid && cmd.idle;
    assign w_we = in_xfer && (action == pcl_pkg::ACT_WEIGHT) && (int'(index) < W_DEPTH);
    assign b_we = in_xfer && (action == pcl_pkg::ACT_BIAS)   && (int'(index) < B_DEPTH);
    assign p_we = in_xfer && (action == pcl_pkg::ACT_PIXEL)  && (int'(index) < P_DEPTH);

    pcl_ram #(
        .WIDTH (DW),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (W_AW'(index)),
        .wdata (value),
        .raddr (wa_reg),
        .rdata (w_rdata)
    );

    pcl_ram #(
        .WIDTH (DW),
        .DEPTH (B_DEPTH)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (B_AW'(index)),
        .wdata (value),
        .raddr (B_AW'(ch_eff)),
        .rdata (b_rdata)
    );

    pcl_ram #(
        .WIDTH (DW),
        .DEPTH (P_DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (P_AW'(index)),
        .wdata (value),
        .raddr (pa_reg),
        .rdata (p_rdata)
    );

    // Hold the partition select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_index_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            part_index_reg <= cfg_write_data;
        end
    end

    // Resolve the cursor against the current partition
    always_comb
    begin
        part_start = part_index_reg ? ROWS_PER_PART : 0;
        part_end   = part_index_reg ? END1 : END0;
        restart    = (part_start + int'(off_reg) >= part_end)
                     || (int'(col_reg) >= OUT_SIZE)
                     || (int'(ch_reg) >= OUT_CHANNELS);
        off_eff    = restart ? '0 : off_reg;
        col_eff    = restart ? '0 : col_reg;
        ch_eff     = restart ? '0 : ch_reg;
        row_eff    = ROW_W'(part_start + int'(off_eff));
        last_eff   = (int'(row_eff) == part_end - 1) && (int'(col_eff) == OUT_SIZE - 1)
                     && (int'(ch_eff) == OUT_CHANNELS - 1);
        wbase      = W_AW'(int'(ch_eff) * TERMS);
        pbase      = P_AW'(int'(row_eff) * IN_SIZE + int'(col_eff));
    end

    // Advance the cursor in row, column, channel order
    always_comb
    begin
        off_next = off_eff;
        col_next = col_eff;
        ch_next  = ch_eff;
        if (last_eff)
        begin
            off_next = '0;
            col_next = '0;
            ch_next  = '0;
        end
        else if (int'(ch_eff) + 1 < OUT_CHANNELS)
        begin
            ch_next = ch_eff + 1'b1;
        end
        else
        begin
            ch_next = '0;
            if (int'(col_eff) + 1 < OUT_SIZE)
            begin
                col_next = col_eff + 1'b1;
            end
            else
            begin
                col_next = '0;
                off_next = off_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            col_reg <= '0;
            ch_reg  <= '0;
        end
        else if (cmd.setup)
        begin
            off_reg <= off_next;
            col_reg <= col_next;
            ch_reg  <= ch_next;
        end
    end

    // Latch coordinates of the output being computed
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            row_pos_reg  <= row_eff;
            col_pos_reg  <= col_eff;
            ch_pos_reg   <= ch_eff;
            last_pos_reg <= last_eff;
        end
    end

    // Term counters over input channel, kernel row, kernel column
    assign kc_end = (int'(kc_reg) == KERNEL - 1);
    assign kr_end = (int'(kr_reg) == KERNEL - 1);
    assign m_end  = (int'(m_reg) == IN_CHANNELS - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            wa_reg <= wbase;
            pa_reg <= pbase;
            kc_reg <= '0;
            kr_reg <= '0;
            m_reg  <= '0;
        end
        else if (cmd.issue)
        begin
            wa_reg <= wa_reg + 1'b1;
            if (!kc_end)
            begin
                kc_reg <= kc_reg + 1'b1;
                pa_reg <= pa_reg + 1'b1;
            end
            else if (!kr_end)
            begin
                kc_reg <= '0;
                kr_reg <= kr_reg + 1'b1;
                pa_reg <= pa_reg + P_AW'(PSTEP_ROW);
            end
            else
            begin
                kc_reg <= '0;
                kr_reg <= '0;
                m_reg  <= m_reg + 1'b1;
                pa_reg <= pa_reg + P_AW'(PSTEP_CH);
            end
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            bias_v_reg <= 1'b0;
            mul_v_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= cmd.issue;
            bias_v_reg <= cmd.setup;
            mul_v_reg  <= rd_v_reg;
        end
    end

    // Multiply, then accumulate the product floored to Q.16
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= $signed(w_rdata) * $signed(p_rdata);
        end
        if (bias_v_reg)
        begin
            acc_reg <= ACC_W'($signed(b_rdata));
        end
        else if (mul_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> pcl_pkg::FRAC_W);
        end
    end

    // Saturate to Q16.16
    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sat_value = {1'b0, {(DW-1){1'b1}}};
            sat_flag  = 1'b1;
        end
        else if (acc_reg < SAT_MIN)
        begin
            sat_value = {1'b1, {(DW-1){1'b0}}};
            sat_flag  = 1'b1;
        end
        else
        begin
            sat_value = acc_reg[DW-1:0];
            sat_flag  = 1'b0;
        end
    end

    // Output register: load on command, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg <= sat_value;
            out_row_reg   <= pcl_pkg::COORD_W'(row_pos_reg);
            out_col_reg   <= pcl_pkg::COORD_W'(col_pos_reg);
            out_ch_reg    <= pcl_pkg::COORD_W'(ch_pos_reg);
            out_last_reg  <= last_pos_reg;
            out_sat_reg   <= sat_flag;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_channel = out_ch_reg;
    assign last        = out_last_reg;
    assign saturated   = out_sat_reg;

    // Status to the controller
    always_comb
    begin
        status.part_empty = part_index_reg ? EMPTY1 : EMPTY0;
        status.issue_last = kc_end && kr_end && m_end;
        status.pipe_busy  = rd_v_reg || mul_v_reg;
        status.out_busy   = out_valid_reg && !out_ready;
    end

endmodule

>>> rtl/partitioned_conv2d_layer.sv
// Partitioned 2-D convolution layer, top level.
// Write transfers (weight, bias, pixel) are taken while the controller is idle.
// An emit transfer runs one multiply-accumulate per cycle over the
// IN_CHANNELS*KERNEL*KERNEL terms, in the single MAC unit fed by registered
// store reads. Input is taken again once the sum is in the output register.
// Reset (rst_n, async) clears the cursor, the partition select and the output
// valid; the stores are not cleared.
// Depends on pcl_pkg, pcl_ctrl, pcl_dp.
module partitioned_conv2d_layer #(
    parameter int OUT_CHANNELS  = pcl_pkg::DEF_OUT_CHANNELS,
    parameter int IN_CHANNELS   = pcl_pkg::DEF_IN_CHANNELS,
    parameter int KERNEL        = pcl_pkg::DEF_KERNEL,
    parameter int IN_SIZE       = pcl_pkg::DEF_IN_SIZE,
    parameter int ROWS_PER_PART = pcl_pkg::DEF_ROWS_PER_PART,
    parameter int PARTS         = pcl_pkg::DEF_PARTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic                               cfg_write_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pcl_pkg::ACTION_W-1:0]       action,
    input  logic [pcl_pkg::INDEX_W-1:0]        index,
    input  logic signed [pcl_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pcl_pkg::DATA_W-1:0]  out_value,
    output logic [pcl_pkg::COORD_W-1:0]        out_row,
    output logic [pcl_pkg::COORD_W-1:0]        out_col,
    output logic [pcl_pkg::COORD_W-1:0]        out_channel,
    output logic                               last,
    output logic                               saturated
);

    pcl_pkg::pcl_cmd_t    cmd;
    pcl_pkg::pcl_status_t status;

    pcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    pcl_dp #(
        .OUT_CHANNELS  (OUT_CHANNELS),
        .IN_CHANNELS   (IN_CHANNELS),
        .KERNEL        (KERNEL),
        .IN_SIZE       (IN_SIZE),
        .ROWS_PER_PART (ROWS_PER_PART),
        .PARTS         (PARTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .action         (action),
        .index          (index),
        .value          (value),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_channel    (out_channel),
        .last           (last),
        .saturated      (saturated),
        .cmd            (cmd),
        .status         (status)
    );

    // Take a transfer only while the controller is idle
    assign in_ready = cmd.idle;

endmodule
